[src/hrmf_pkg.sv]
// ----------------------------------------------------------------------------
// hrmf_pkg
// Shared types and wire codes of the HID report message framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hrmf_pkg;

    localparam logic [6:0] CMD_PING  = 7'h01;
    localparam logic [6:0] CMD_LOCK  = 7'h04;
    localparam logic [6:0] CMD_INIT  = 7'h06;
    localparam logic [6:0] CMD_WINK  = 7'h08;
    localparam logic [6:0] CMD_ERROR = 7'h3F;

    localparam logic [7:0] ERR_CMD  = 8'h01;
    localparam logic [7:0] ERR_LEN  = 8'h03;
    localparam logic [7:0] ERR_SEQ  = 8'h04;
    localparam logic [7:0] ERR_BUSY = 8'h06;
    localparam logic [7:0] ERR_CHAN = 8'h0B;

    localparam logic [31:0] BCAST_ID = 32'hFFFF_FFFF;

    localparam logic [1:0] REG_MAX_PKTS = 2'd0;
    localparam logic [1:0] REG_VERSION  = 2'd1;
    localparam logic [1:0] REG_CAPS     = 2'd2;

    localparam int INIT_ROOM = 57;
    localparam int CONT_ROOM = 59;

    typedef struct packed {
        logic        func;
        logic [63:0] in_word_0;
        logic [63:0] in_word_1;
        logic [63:0] in_word_2;
        logic [63:0] in_word_3;
        logic [63:0] in_word_4;
        logic [63:0] in_word_5;
        logic [63:0] in_word_6;
        logic [63:0] in_word_7;
    } hrmf_in_t;

    typedef struct packed {
        logic [63:0] out_word_0;
        logic [63:0] out_word_1;
        logic [63:0] out_word_2;
        logic [63:0] out_word_3;
        logic [63:0] out_word_4;
        logic [63:0] out_word_5;
        logic [63:0] out_word_6;
        logic [63:0] out_word_7;
        logic        last_of_run;
        logic        more_pending;
    } hrmf_out_t;

endpackage

`default_nettype wire

[src/hid_report_message_framer_unit.sv]
// ----------------------------------------------------------------------------
// hid_report_message_framer_unit
// CTAPHID framing: reassembles requests from reports, stages and segments
// responses, one byte per cycle through the stores.
//
//   channel   handshake            payload
//   request   start / busy         in     (hrmf_in_t)
//   result    done strobe          result (hrmf_out_t)
//   config    cfg_wr_en            cfg_addr, cfg_data
//
// A request is decoded; then an INIT reply is built, or the payload is
// absorbed into the request store, a PING copied to the reply store and
// packets emitted byte by byte through the store ports. Reset is
// asynchronous and clears control state only; the stores need no clearing.
// Results cannot be stalled: each is shown for one cycle on done.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_message_framer_unit
    import hrmf_pkg::*;
#(
    parameter int MAX_MESSAGE = 1024
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire hrmf_in_t  in,
    output logic           done,
    output hrmf_out_t      result,
    input  wire logic      cfg_wr_en,
    input  wire logic [1:0] cfg_addr,
    input  wire logic [7:0] cfg_data
);

    localparam int AW = $clog2(MAX_MESSAGE);
    localparam int LW = $clog2(MAX_MESSAGE + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_INITREP, S_ABSORB, S_DISPATCH, S_COPY, S_EMIT, S_SEND
    } state_t;

    state_t       state_reg;
    logic [4:0]   max_pkts_reg;
    logic [7:0]   version_reg;
    logic [7:0]   caps_reg;
    logic [511:0] pkt_reg;
    logic [511:0] out_reg;
    logic [31:0]  channel_reg;
    logic         assembling_reg;
    logic [6:0]   req_cmd_reg;
    logic [LW-1:0] req_len_reg;
    logic [LW-1:0] req_pos_reg;
    logic [7:0]   exp_seq_reg;
    logic [5:0]   space_reg;
    logic [6:0]   rep_cmd_reg;
    logic [31:0]  rep_chan_reg;
    logic [LW-1:0] rep_len_reg;
    logic [LW-1:0] rep_sent_reg;
    logic [7:0]   rep_seq_reg;
    logic         pending_reg;
    logic         started_reg;
    logic [4:0]   k_reg;
    logic [LW-1:0] copy_reg;
    logic         wv_reg;
    logic [AW-1:0] wa_reg;
    logic [5:0]   b_reg;
    logic [5:0]   dcnt_reg;
    logic [AW-1:0] rptr_reg;
    logic [4:0]   n_reg;

    logic [31:0] cid;
    logic [7:0]  p4;
    logic [15:0] bcnt;
    logic [31:0] nc_raw;
    logic [31:0] nc;
    logic [4:0]  cap;
    logic        err_hit;
    logic [7:0]  err_code;

    logic          req_we;
    logic [7:0]    req_rdata;
    logic          rep_we;
    logic [AW-1:0] rep_waddr;
    logic [7:0]    rep_wdata;
    logic [7:0]    rep_rdata;
    logic [7:0]    init_byte;

    logic [LW-1:0] remain;
    logic [LW-1:0] room;
    logic [5:0]    hdr;
    logic          data_sel;
    logic [7:0]    emit_byte;
    logic [15:0]   len16;
    logic          last_pkt;

    assign cid    = pkt_reg[511:480];
    assign p4     = pkt_reg[479:472];
    assign bcnt   = pkt_reg[471:456];
    assign nc_raw = channel_reg + 32'd1;
    assign nc     = (nc_raw == 32'd0 || nc_raw == BCAST_ID) ? 32'd1 : nc_raw;
    assign cap    = (max_pkts_reg == 5'd0) ? 5'd1 :
                    (max_pkts_reg > 5'd16) ? 5'd16 : max_pkts_reg;

    always_comb
    begin
        err_hit  = 1'b0;
        err_code = ERR_CMD;
        if (p4[7])
        begin
            if (cid != BCAST_ID)
            begin
                err_hit = 1'b1;
                if (cid == 32'd0 || cid != channel_reg)
                    err_code = ERR_CHAN;
                else if (assembling_reg)
                    err_code = ERR_BUSY;
                else if (bcnt > 16'(MAX_MESSAGE))
                    err_code = ERR_LEN;
                else
                    err_hit = 1'b0;
            end
        end
        else if (cid != channel_reg || !assembling_reg || {1'b0, p4[6:0]} != exp_seq_reg)
        begin
            err_hit  = 1'b1;
            err_code = ERR_SEQ;
        end
    end

    always_comb
    begin
        unique case (k_reg)
            5'd8:    init_byte = channel_reg[31:24];
            5'd9:    init_byte = channel_reg[23:16];
            5'd10:   init_byte = channel_reg[15:8];
            5'd11:   init_byte = channel_reg[7:0];
            5'd12:   init_byte = version_reg;
            5'd16:   init_byte = caps_reg;
            default: init_byte = (k_reg < 5'd8) ? pkt_reg[511:504] : 8'h00;
        endcase
    end

    always_comb
    begin
        rep_we    = 1'b0;
        rep_waddr = '0;
        rep_wdata = err_code;
        req_we    = (state_reg == S_ABSORB) && (req_pos_reg < req_len_reg)
                    && (space_reg != 6'd0);
        unique case (state_reg)
            S_DECODE:
            begin
                rep_we = err_hit;
            end
            S_INITREP:
            begin
                rep_we    = 1'b1;
                rep_waddr = AW'(k_reg);
                rep_wdata = init_byte;
            end
            S_COPY:
            begin
                rep_we    = wv_reg;
                rep_waddr = wa_reg;
                rep_wdata = req_rdata;
            end
            S_DISPATCH:
            begin
                rep_we    = !(req_cmd_reg == CMD_PING || req_cmd_reg == CMD_WINK
                              || req_cmd_reg == CMD_LOCK);
                rep_wdata = ERR_CMD;
            end
            default:
            begin
                rep_we = 1'b0;
            end
        endcase
    end

    assign len16    = 16'(rep_len_reg);
    assign hdr      = started_reg ? 6'd5 : 6'd7;
    assign remain   = rep_len_reg - rep_sent_reg;
    assign room     = (remain > LW'(64 - 32'(hdr))) ? LW'(64 - 32'(hdr)) : remain;
    assign data_sel = (b_reg >= hdr) && (LW'(dcnt_reg) < room);
    assign last_pkt = !pending_reg || (n_reg + 5'd1 >= cap);

    always_comb
    begin
        unique case (b_reg)
            6'd0:    emit_byte = rep_chan_reg[31:24];
            6'd1:    emit_byte = rep_chan_reg[23:16];
            6'd2:    emit_byte = rep_chan_reg[15:8];
            6'd3:    emit_byte = rep_chan_reg[7:0];
            6'd4:    emit_byte = started_reg ? {1'b0, rep_seq_reg[6:0]}
                                             : {1'b1, rep_cmd_reg};
            6'd5:    emit_byte = started_reg ? (data_sel ? rep_rdata : 8'h00) : len16[15:8];
            6'd6:    emit_byte = started_reg ? (data_sel ? rep_rdata : 8'h00) : len16[7:0];
            default: emit_byte = data_sel ? rep_rdata : 8'h00;
        endcase
    end

    hrmf_byte_ram #(.DEPTH(MAX_MESSAGE)) u_req_ram (
        .clk   (clk),
        .we    (req_we),
        .waddr (req_pos_reg[AW-1:0]),
        .wdata (pkt_reg[511:504]),
        .raddr (copy_reg[AW-1:0]),
        .rdata (req_rdata)
    );

    hrmf_byte_ram #(.DEPTH(MAX_MESSAGE)) u_rep_ram (
        .clk   (clk),
        .we    (rep_we),
        .waddr (rep_waddr),
        .wdata (rep_wdata),
        .raddr (rptr_reg),
        .rdata (rep_rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_SEND);

    always_comb
    begin
        result.out_word_0   = out_reg[511:448];
        result.out_word_1   = out_reg[447:384];
        result.out_word_2   = out_reg[383:320];
        result.out_word_3   = out_reg[319:256];
        result.out_word_4   = out_reg[255:192];
        result.out_word_5   = out_reg[191:128];
        result.out_word_6   = out_reg[127:64];
        result.out_word_7   = out_reg[63:0];
        result.last_of_run  = last_pkt;
        result.more_pending = pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_pkts_reg   <= 5'd1;
            version_reg    <= 8'd2;
            caps_reg       <= 8'd4;
            channel_reg    <= '0;
            assembling_reg <= 1'b0;
            req_cmd_reg    <= '0;
            req_len_reg    <= '0;
            req_pos_reg    <= '0;
            exp_seq_reg    <= '0;
            space_reg      <= '0;
            rep_cmd_reg    <= '0;
            rep_chan_reg   <= '0;
            rep_len_reg    <= '0;
            rep_sent_reg   <= '0;
            rep_seq_reg    <= '0;
            pending_reg    <= 1'b0;
            started_reg    <= 1'b0;
            k_reg          <= '0;
            copy_reg       <= '0;
            wv_reg         <= 1'b0;
            wa_reg         <= '0;
            b_reg          <= '0;
            dcnt_reg       <= '0;
            rptr_reg       <= '0;
            n_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    REG_MAX_PKTS: max_pkts_reg <= cfg_data[4:0];
                    REG_VERSION:  version_reg  <= cfg_data;
                    REG_CAPS:     caps_reg     <= cfg_data;
                    default:      ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg    <= '0;
                        b_reg    <= '0;
                        dcnt_reg <= '0;
                        rptr_reg <= rep_sent_reg[AW-1:0];
                        if (pending_reg)
                            state_reg <= S_EMIT;
                        else if (!in.func)
                        begin
                            pkt_reg   <= {in.in_word_0, in.in_word_1, in.in_word_2,
                                          in.in_word_3, in.in_word_4, in.in_word_5,
                                          in.in_word_6, in.in_word_7};
                            state_reg <= S_DECODE;
                        end
                    end
                end
                S_DECODE:
                begin
                    if (err_hit)
                    begin
                        rep_cmd_reg  <= CMD_ERROR;
                        rep_chan_reg <= cid;
                        rep_len_reg  <= LW'(1);
                        rep_sent_reg <= '0;
                        rep_seq_reg  <= '0;
                        pending_reg  <= 1'b1;
                        started_reg  <= 1'b0;
                        rptr_reg     <= '0;
                        state_reg    <= S_EMIT;
                    end
                    else if (p4[7] && cid == BCAST_ID)
                    begin
                        if (p4[6:0] != CMD_INIT || bcnt < 16'd8)
                            state_reg <= S_IDLE;
                        else
                        begin
                            channel_reg <= nc;
                            pkt_reg     <= pkt_reg << 56;
                            k_reg       <= '0;
                            state_reg   <= S_INITREP;
                        end
                    end
                    else if (p4[7])
                    begin
                        req_cmd_reg    <= p4[6:0];
                        req_len_reg    <= bcnt[LW-1:0];
                        req_pos_reg    <= '0;
                        exp_seq_reg    <= '0;
                        assembling_reg <= 1'b1;
                        pkt_reg        <= pkt_reg << 56;
                        space_reg      <= 6'(INIT_ROOM);
                        state_reg      <= S_ABSORB;
                    end
                    else
                    begin
                        exp_seq_reg <= {1'b0, p4[6:0]} + 8'd1;
                        pkt_reg     <= pkt_reg << 40;
                        space_reg   <= 6'(CONT_ROOM);
                        state_reg   <= S_ABSORB;
                    end
                end
                S_INITREP:
                begin
                    pkt_reg <= pkt_reg << 8;
                    k_reg   <= k_reg + 5'd1;
                    if (k_reg == 5'd16)
                    begin
                        rep_cmd_reg  <= CMD_INIT;
                        rep_chan_reg <= BCAST_ID;
                        rep_len_reg  <= LW'(17);
                        rep_sent_reg <= '0;
                        rep_seq_reg  <= '0;
                        pending_reg  <= 1'b1;
                        started_reg  <= 1'b0;
                        rptr_reg     <= '0;
                        state_reg    <= S_EMIT;
                    end
                end
                S_ABSORB:
                begin
                    if (req_we)
                    begin
                        pkt_reg     <= pkt_reg << 8;
                        req_pos_reg <= req_pos_reg + LW'(1);
                        space_reg   <= space_reg - 6'd1;
                    end
                    else if (req_pos_reg >= req_len_reg)
                    begin
                        assembling_reg <= 1'b0;
                        state_reg      <= S_DISPATCH;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_DISPATCH:
                begin
                    rep_chan_reg <= channel_reg;
                    rep_sent_reg <= '0;
                    rep_seq_reg  <= '0;
                    started_reg  <= 1'b0;
                    rptr_reg     <= '0;
                    copy_reg     <= '0;
                    wv_reg       <= 1'b0;
                    if (req_cmd_reg == CMD_PING)
                        state_reg <= S_COPY;
                    else
                    begin
                        pending_reg <= 1'b1;
                        state_reg   <= S_EMIT;
                        if (req_cmd_reg == CMD_WINK || req_cmd_reg == CMD_LOCK)
                        begin
                            rep_cmd_reg <= req_cmd_reg;
                            rep_len_reg <= '0;
                        end
                        else
                        begin
                            rep_cmd_reg <= CMD_ERROR;
                            rep_len_reg <= LW'(1);
                        end
                    end
                end
                S_COPY:
                begin
                    if (copy_reg < req_len_reg)
                    begin
                        copy_reg <= copy_reg + LW'(1);
                        wv_reg   <= 1'b1;
                        wa_reg   <= copy_reg[AW-1:0];
                    end
                    else
                    begin
                        wv_reg      <= 1'b0;
                        rep_cmd_reg <= CMD_PING;
                        rep_len_reg <= req_len_reg;
                        pending_reg <= 1'b1;
                        state_reg   <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    out_reg <= {out_reg[503:0], emit_byte};
                    b_reg   <= b_reg + 6'd1;
                    if (b_reg >= hdr - 6'd1)
                        rptr_reg <= rptr_reg + AW'(1);
                    if (data_sel)
                        dcnt_reg <= dcnt_reg + 6'd1;
                    if (b_reg == 6'd63)
                    begin
                        rep_sent_reg <= rep_sent_reg + room;
                        pending_reg  <= (rep_sent_reg + room) < rep_len_reg;
                        started_reg  <= 1'b1;
                        if (started_reg)
                            rep_seq_reg <= rep_seq_reg + 8'd1;
                        state_reg <= S_SEND;
                    end
                end
                S_SEND:
                begin
                    b_reg    <= '0;
                    dcnt_reg <= '0;
                    rptr_reg <= rep_sent_reg[AW-1:0];
                    n_reg    <= n_reg + 5'd1;
                    state_reg <= last_pkt ? S_IDLE : S_EMIT;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_more_means_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.more_pending |-> result.last_of_run)
        else $error("packet with nothing pending not marked last");
    a_sent_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rep_sent_reg <= rep_len_reg)
        else $error("reply sent count past reply length");
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last_of_run |=> busy && !done)
        else $error("run ended without a last packet");
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && pending_reg |=> state_reg == S_EMIT)
        else $error("pending reply not drained on request");
`endif

endmodule

`default_nettype wire

[src/hrmf_byte_ram.sv]
// ----------------------------------------------------------------------------
// hrmf_byte_ram
// Byte-wide message store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hrmf_byte_ram #(
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [7:0]               wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [7:0]               rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HID report message framer. Directed reports
// hit the channel, sequence, length and busy checks, then random messages,
// broken sequences and noise run under several register settings. A local
// predictor of the framer state builds every expected response packet.
// ----------------------------------------------------------------------------

module tb;
    import hrmf_pkg::*;

    localparam logic [6:0] CMD_MSG      = 7'h03;
    localparam logic [6:0] CMD_CBOR     = 7'h10;
    localparam logic [6:0] CMD_RESERVED = 7'h7F;
    localparam int         MSG_MAX      = 1024;

    class frame_scoreboard;
        logic [4:0]  max_pkts = 5'd1;
        logic [7:0]  version  = 8'd2;
        logic [7:0]  caps     = 8'd4;
        logic [31:0] chan       = 32'd0;
        logic        assembling = 1'b0;
        logic [6:0]  req_cmd    = 7'd0;
        int          req_len    = 0;
        int          req_pos    = 0;
        logic [7:0]  exp_seq    = 8'd0;
        logic [7:0]  req_mem [MSG_MAX];
        logic [7:0]  rep_mem [MSG_MAX];
        logic [6:0]  rep_cmd    = 7'd0;
        logic [31:0] rep_chan   = 32'd0;
        int          rep_len    = 0;
        int          rep_sent   = 0;
        logic [7:0]  rep_seq    = 8'd0;
        logic        pending    = 1'b0;
        logic        started    = 1'b0;
        hrmf_out_t   expected_packets [$];
        int          errors     = 0;
        int          checked    = 0;

        function void configure(logic [1:0] addr, logic [7:0] data);
            if (addr == REG_MAX_PKTS) max_pkts = data[4:0];
            else if (addr == REG_VERSION) version = data;
            else if (addr == REG_CAPS) caps = data;
        endfunction

        function void stage(logic [6:0] cmd, logic [31:0] target, int len);
            rep_cmd  = cmd;
            rep_chan = target;
            rep_len  = (len > MSG_MAX) ? MSG_MAX : len;
            rep_sent = 0;
            rep_seq  = 0;
            pending  = 1'b1;
            started  = 1'b0;
        endfunction

        function void stage_err(logic [31:0] target, logic [7:0] code);
            rep_mem[0] = code;
            stage(CMD_ERROR, target, 1);
        endfunction

        function void emit();
            int cap;
            int n;
            int hdr;
            int room;
            logic [7:0]  p [64];
            logic [63:0] w [8];
            hrmf_out_t   o;
            cap = max_pkts;
            if (cap < 1) cap = 1;
            if (cap > 16) cap = 16;
            n = 0;
            while (pending && n < cap) begin
                foreach (p[i]) p[i] = 8'h00;
                {p[0], p[1], p[2], p[3]} = rep_chan;
                if (!started) begin
                    p[4] = {1'b1, rep_cmd};
                    {p[5], p[6]} = rep_len[15:0];
                    hdr = 7;
                    started = 1'b1;
                end else begin
                    p[4] = {1'b0, rep_seq[6:0]};
                    rep_seq = rep_seq + 8'd1;
                    hdr = 5;
                end
                room = rep_len - rep_sent;
                if (room > 64 - hdr) room = 64 - hdr;
                for (int k = 0; k < room; k++) p[hdr + k] = rep_mem[rep_sent + k];
                rep_sent += room;
                pending = rep_sent < rep_len;
                for (int j = 0; j < 8; j++)
                    w[j] = {p[8*j], p[8*j+1], p[8*j+2], p[8*j+3],
                            p[8*j+4], p[8*j+5], p[8*j+6], p[8*j+7]};
                o = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], 1'b0, pending};
                expected_packets.push_back(o);
                n++;
            end
            if (n > 0) expected_packets[expected_packets.size() - 1].last_of_run = 1'b1;
        endfunction

        function void absorb(logic [7:0] p [64], int hdr);
            int take;
            take = req_len - req_pos;
            if (take > 64 - hdr) take = 64 - hdr;
            for (int k = 0; k < take; k++) req_mem[req_pos + k] = p[hdr + k];
            req_pos += take;
            if (req_pos >= req_len) begin
                assembling = 1'b0;
                case (req_cmd)
                    CMD_PING: begin
                        for (int k = 0; k < req_len; k++) rep_mem[k] = req_mem[k];
                        stage(CMD_PING, chan, req_len);
                    end
                    CMD_WINK: stage(CMD_WINK, chan, 0);
                    CMD_LOCK: stage(CMD_LOCK, chan, 0);
                    default:  stage_err(chan, ERR_CMD);
                endcase
            end
        endfunction

        function void note_request(hrmf_in_t r);
            logic [63:0] w [8];
            logic [7:0]  p [64];
            logic [31:0] cid;
            logic [31:0] nc;
            logic [15:0] bcnt;
            logic [6:0]  cmd;
            if (pending) begin
                emit();
                return;
            end
            if (r.func) return;
            w = '{r.in_word_0, r.in_word_1, r.in_word_2, r.in_word_3,
                  r.in_word_4, r.in_word_5, r.in_word_6, r.in_word_7};
            for (int i = 0; i < 64; i++) p[i] = w[i / 8][63 - 8 * (i % 8) -: 8];
            cid  = {p[0], p[1], p[2], p[3]};
            bcnt = {p[5], p[6]};
            cmd  = p[4][6:0];
            if (p[4][7]) begin
                if (cid == BCAST_ID) begin
                    if (cmd != CMD_INIT || bcnt < 8) return;
                    nc = chan + 32'd1;
                    while (nc == BCAST_ID || nc == 32'd0) nc++;
                    chan = nc;
                    for (int k = 0; k < 8; k++) rep_mem[k] = p[7 + k];
                    {rep_mem[8], rep_mem[9], rep_mem[10], rep_mem[11]} = nc;
                    rep_mem[12] = version;
                    rep_mem[13] = 8'h00;
                    rep_mem[14] = 8'h00;
                    rep_mem[15] = 8'h00;
                    rep_mem[16] = caps;
                    stage(CMD_INIT, BCAST_ID, 17);
                end else if (cid == 32'd0 || cid != chan) begin
                    stage_err(cid, ERR_CHAN);
                end else if (assembling) begin
                    stage_err(cid, ERR_BUSY);
                end else if (bcnt > MSG_MAX) begin
                    stage_err(cid, ERR_LEN);
                end else begin
                    req_cmd    = cmd;
                    req_len    = bcnt;
                    req_pos    = 0;
                    exp_seq    = 8'd0;
                    assembling = 1'b1;
                    absorb(p, 7);
                end
            end else if (cid != chan || !assembling || {1'b0, cmd} != exp_seq) begin
                stage_err(cid, ERR_SEQ);
            end else begin
                exp_seq = {1'b0, cmd} + 8'd1;
                absorb(p, 5);
            end
            emit();
        endfunction

        function void check_result(hrmf_out_t got);
            hrmf_out_t   exp_pkt;
            logic [63:0] ew [8];
            logic [63:0] gw [8];
            if (expected_packets.size() == 0) begin
                $display("%0t: unexpected response packet %h", $time, got);
                errors++;
                return;
            end
            exp_pkt = expected_packets.pop_front();
            checked++;
            ew = '{exp_pkt.out_word_0, exp_pkt.out_word_1, exp_pkt.out_word_2,
                   exp_pkt.out_word_3, exp_pkt.out_word_4, exp_pkt.out_word_5,
                   exp_pkt.out_word_6, exp_pkt.out_word_7};
            gw = '{got.out_word_0, got.out_word_1, got.out_word_2, got.out_word_3,
                   got.out_word_4, got.out_word_5, got.out_word_6, got.out_word_7};
            for (int j = 0; j < 8; j++)
                if (gw[j] !== ew[j]) begin
                    $display("%0t: out_word_%0d expected %h actual %h", $time, j, ew[j], gw[j]);
                    errors++;
                end
            if (got.last_of_run !== exp_pkt.last_of_run) begin
                $display("%0t: last_of_run expected %b actual %b", $time,
                         exp_pkt.last_of_run, got.last_of_run);
                errors++;
            end
            if (got.more_pending !== exp_pkt.more_pending) begin
                $display("%0t: more_pending expected %b actual %b", $time,
                         exp_pkt.more_pending, got.more_pending);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    hrmf_in_t   report = '0;
    logic       done;
    hrmf_out_t  result;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = REG_MAX_PKTS;
    logic [7:0] cfg_data = 8'h00;

    frame_scoreboard sb = new();
    int idle_pct;
    int sent;

    hid_report_message_framer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in        (report),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(result);
    end

    initial
    begin
        #60_000_000;
        $display("hid_report_message_framer_unit: mismatch");
        $finish;
    end

    function automatic hrmf_in_t make_report(logic [31:0] cid, logic [7:0] b4,
                                             logic [15:0] b56);
        hrmf_in_t r;
        r.func      = 1'b0;
        r.in_word_0 = {cid, b4, b56, 8'($urandom)};
        r.in_word_1 = {$urandom, $urandom};
        r.in_word_2 = {$urandom, $urandom};
        r.in_word_3 = {$urandom, $urandom};
        r.in_word_4 = {$urandom, $urandom};
        r.in_word_5 = {$urandom, $urandom};
        r.in_word_6 = {$urandom, $urandom};
        r.in_word_7 = {$urandom, $urandom};
        return r;
    endfunction

    task automatic send(input hrmf_in_t req);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        report <= req;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(req);
        sent++;
    endtask

    // drain staged response; the first request carries a report to be dropped
    task automatic drain_pending();
        hrmf_in_t r;
        int       first;
        first = 1;
        while (sb.pending)
        begin
            r = make_report({$urandom}, 8'($urandom), 16'($urandom));
            r.func = first ? 1'b0 : 1'($urandom_range(1));
            first = 0;
            send(r);
        end
    endtask

    task automatic send_message(input logic [6:0] cmd, input int len, input int cpct);
        int kind;
        send(make_report(sb.chan, {1'b1, cmd}, 16'(len)));
        drain_pending();
        while (sb.assembling)
        begin
            if ($urandom_range(99) < cpct)
            begin
                kind = $urandom_range(2);
                if (kind == 0)
                    send(make_report(sb.chan, {1'b0, 7'(sb.exp_seq + 8'd1)}, 16'($urandom)));
                else if (kind == 1)
                    send(make_report(sb.chan ^ 32'h1, {1'b0, sb.exp_seq[6:0]},
                                     16'($urandom)));
                else
                    send(make_report(sb.chan, {1'b1, CMD_PING}, 16'($urandom_range(100))));
                drain_pending();
            end
            send(make_report(sb.chan, {1'b0, sb.exp_seq[6:0]}, 16'($urandom)));
            drain_pending();
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.expected_packets.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] pkts, input logic [7:0] ver,
                              input logic [7:0] cap);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_MAX_PKTS;
        cfg_data  <= pkts;
        @(posedge clk);
        sb.configure(REG_MAX_PKTS, pkts);
        cfg_addr <= REG_VERSION;
        cfg_data <= ver;
        @(posedge clk);
        sb.configure(REG_VERSION, ver);
        cfg_addr <= REG_CAPS;
        cfg_data <= cap;
        @(posedge clk);
        sb.configure(REG_CAPS, cap);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int        k;
        int        r;
        int        len;
        logic [6:0] cmd;
        hrmf_in_t  noise;
        while (sent < target)
        begin
            k = $urandom_range(99);
            if (k < 8 && !sb.assembling)
            begin
                r = $urandom_range(9);
                send(make_report(BCAST_ID, (r == 0) ? 8'($urandom) : {1'b1, CMD_INIT},
                                 (r == 1) ? 16'($urandom_range(7)) : 16'($urandom_range(8, 64))));
                drain_pending();
            end
            else if (k < 70)
            begin
                r = $urandom_range(9);
                cmd = (r < 5) ? CMD_PING : (r == 5) ? CMD_WINK : (r == 6) ? CMD_LOCK :
                      (r == 7) ? CMD_CBOR : (r == 8) ? CMD_MSG : 7'($urandom);
                r = $urandom_range(99);
                len = (r < 2) ? MSG_MAX : (r < 5) ? $urandom_range(MSG_MAX + 1, 65535) :
                      (r < 60) ? $urandom_range(57) : $urandom_range(58, 300);
                send_message(cmd, len, 10);
            end
            else
            begin
                noise = make_report({$urandom}, 8'($urandom), 16'($urandom));
                noise.func = 1'($urandom_range(1));
                if ($urandom_range(1)) noise.in_word_0[63:32] = sb.chan;
                if (noise.in_word_0[63:32] == BCAST_ID) noise.in_word_0[32] = 1'b0;
                send(noise);
                drain_pending();
            end
        end
    endtask

    initial
    begin
        hrmf_in_t    r;
        logic [7:0]  cfg_table [6][3];
        cfg_table = '{'{8'd1, 8'h00, 8'h00}, '{8'd16, 8'hFF, 8'hFF},
                      '{8'hFF, 8'h5A, 8'hA5}, '{8'd0, 8'h02, 8'h04},
                      '{8'd3, 8'h12, 8'h34}, '{8'd17, 8'hC3, 8'h3C}};
        sent = 0;
        idle_pct = 10;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_regs(cfg_table[0][0], cfg_table[0][1], cfg_table[0][2]);

        r = make_report(32'h0, 8'h00, 16'h0);
        r.func = 1'b1;
        send(r);
        send(make_report(32'h0, 8'h00, 16'h0));
        drain_pending();
        send(make_report(32'h0, {1'b1, CMD_PING}, 16'd4));
        drain_pending();
        send(make_report(BCAST_ID, {1'b1, CMD_PING}, 16'd8));
        send(make_report(BCAST_ID, {1'b1, CMD_INIT}, 16'd7));
        send(make_report(BCAST_ID, {1'b1, CMD_INIT}, 16'd8));
        drain_pending();
        send(make_report(sb.chan + 32'd5, {1'b1, CMD_WINK}, 16'd0));
        drain_pending();
        send(make_report(sb.chan, 8'h00, 16'h0));
        drain_pending();
        send_message(CMD_PING, 0, 0);
        send_message(CMD_WINK, 0, 0);
        send_message(CMD_LOCK, 0, 0);
        send_message(CMD_CBOR, 10, 0);
        send_message(CMD_MSG, 10, 0);
        send_message(CMD_INIT, 8, 0);
        send_message(CMD_RESERVED, 3, 0);
        send_message(CMD_PING, MSG_MAX + 1, 0);
        send_message(CMD_PING, 65535, 0);
        send_message(CMD_PING, 200, 100);
        send_message(CMD_PING, 60, 0);

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = (ph < 2) ? 10 : (ph < 4) ? 66 : 0;
            if (ph > 0)
            begin
                settle();
                write_regs(cfg_table[ph][0], cfg_table[ph][1], cfg_table[ph][2]);
            end
            if (ph == 1) send_message(CMD_PING, MSG_MAX, 0);
            run_random(25 + 34 * (ph + 1));
        end
        settle();

        $display("Sent %0d requests over 6 register settings; %0d response packets checked.",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("hid_report_message_framer_unit: match");
        else
            $display("hid_report_message_framer_unit: mismatch");
        $finish;
    end

endmodule
